/* sv/plane3_pkg.sv */
`timescale 1ns / 1ps
// shared constants for the plane-from-three-points pipeline
// no dependencies

package plane3_pkg;

    localparam int COORD_WIDTH = 32;   // default coordinate width
    localparam int PORT_WIDTH  = 32;   // width of each coordinate port
    localparam int C_WIDTH     = 32;   // scaled cross component
    localparam int SUM_WIDTH   = 64;   // sum of squares
    localparam int ROOT_WIDTH  = 32;   // square root result
    localparam int NUM_WIDTH   = 63;   // dividend
    localparam int Q_WIDTH     = 33;   // quotient
    localparam int N_WIDTH     = 34;   // signed normal before truncation
    localparam int NORM_WIDTH  = 32;   // normal output
    localparam int D_WIDTH     = 48;   // offset output
    localparam int FRAC_SHIFT  = 30;   // Q1.30 scale

endpackage

/* sv/plane_from_three_points.sv */
`timescale 1ns / 1ps
// plane_from_three_points: unit normal and offset of the plane through three points
// depends on plane3_pkg
// a word passes stages a to g, the square root and divider stages, j, k and the output stage
// throughput: one word per cycle unless stalled, set by the bit-per-stage square root and
// divider pipelines; a stalled output holds the whole pipeline; no word is lost or repeated
// reset clears all valid bits; no clearing pass, data registers are not reset

module plane_from_three_points #(
    parameter int COORD_WIDTH = plane3_pkg::COORD_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] first_x,
    input  logic [31:0] first_y,
    input  logic [31:0] first_z,
    input  logic [31:0] second_x,
    input  logic [31:0] second_y,
    input  logic [31:0] second_z,
    input  logic [31:0] third_x,
    input  logic [31:0] third_y,
    input  logic [31:0] third_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic signed [47:0] offset_d,
    output logic        degenerate
);

    localparam int CW   = COORD_WIDTH;
    localparam int PTW  = plane3_pkg::PORT_WIDTH;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int LW   = $clog2(XW + 1);
    localparam int CCW  = plane3_pkg::C_WIDTH;
    localparam int SW   = plane3_pkg::SUM_WIDTH;
    localparam int RTW  = plane3_pkg::ROOT_WIDTH;
    localparam int RMW  = RTW + 3;
    localparam int NMW  = plane3_pkg::NUM_WIDTH;
    localparam int QW   = plane3_pkg::Q_WIDTH;
    localparam int DRW  = RTW + 1;
    localparam int NW   = plane3_pkg::N_WIDTH;
    localparam int FS   = plane3_pkg::FRAC_SHIFT;
    localparam int NPW  = NW + CW;
    localparam int ACW  = NPW + 3;
    localparam int SHW  = ACW - FS;
    localparam int OW   = plane3_pkg::D_WIDTH;
    localparam int CMPW = (SHW > OW + 1) ? SHW : OW + 1;
    localparam int SQS  = RTW;
    localparam int DVS  = QW;
    localparam int NORM_BITS = plane3_pkg::NORM_WIDTH;

    typedef struct packed {
        logic [2:0][CW-1:0]  p1;
        logic [2:0]          neg;
        logic [2:0][CCW-1:0] mag;
        logic                deg;
    } carry_t;

    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic [8:0][PTW-1:0] in_w;
    logic [8:0][CW-1:0]  crd;
    assign in_w = {third_z, third_y, third_x, second_z, second_y, second_x,
                   first_z, first_y, first_x};

    genvar gi;
    generate
        for (gi = 0; gi < 9; gi++)
        begin : g_crd
            if (CW <= PTW)
            begin : g_narrow
                assign crd[gi] = in_w[gi][CW-1:0];
            end
            else
            begin : g_wide
                assign crd[gi] = {{(CW-PTW){1'b0}}, in_w[gi]};
            end
        end
    endgenerate

    // stage a: coordinates
    logic               a_valid_reg;
    logic [8:0][CW-1:0] a_p_reg;

    // stage b: edge vectors
    logic               b_valid_reg;
    logic [2:0][DW-1:0] b_v1_reg, b_v2_reg;
    logic [2:0][CW-1:0] b_p1_reg;

    // stage c: partial products
    logic               c_valid_reg;
    logic [5:0][PW-1:0] c_m_reg;
    logic [2:0][CW-1:0] c_p1_reg;

    // stage d: cross product
    logic               d_valid_reg;
    logic [2:0][XW-1:0] d_x_reg;
    logic [2:0][CW-1:0] d_p1_reg;

    // stage e: bit length
    logic               e_valid_reg;
    logic [2:0][XW-1:0] e_x_reg;
    logic [LW-1:0]      e_len_reg;
    logic [2:0][CW-1:0] e_p1_reg;

    // stage f: scaled components
    logic                f_valid_reg;
    logic [2:0][CCW-1:0] f_c_reg;
    logic                f_deg_reg;
    logic [2:0][CW-1:0]  f_p1_reg;

    // stage g: squares
    logic               g_valid_reg;
    logic [2:0][SW-1:0] g_sq_reg;
    carry_t             g_cr_reg;

    // square root stages
    logic [SQS:0]       sq_valid_reg;
    logic [SW-1:0]      sq_x_reg    [SQS+1];
    logic [RMW-1:0]     sq_rem_reg  [SQS+1];
    logic [RTW-1:0]     sq_root_reg [SQS+1];
    carry_t             sq_cr_reg   [SQS+1];

    // divider stages
    logic [DVS:0]        dv_valid_reg;
    logic [2:0][NMW-1:0] dv_num_reg [DVS+1];
    logic [2:0][DRW-1:0] dv_rem_reg [DVS+1];
    logic [2:0][QW-1:0]  dv_q_reg   [DVS+1];
    logic [RTW-1:0]      dv_m_reg   [DVS+1];
    carry_t              dv_cr_reg  [DVS+1];

    // stage j: signed normal
    logic               j_valid_reg;
    logic [2:0][NW-1:0] j_n_reg;
    logic [2:0][CW-1:0] j_p1_reg;
    logic               j_deg_reg;

    // stage k: offset products
    logic                k_valid_reg;
    logic [2:0][NPW-1:0] k_pr_reg;
    logic [2:0][NW-1:0]  k_n_reg;
    logic                k_deg_reg;

    // output stage
    logic               o_valid_reg;
    logic [2:0][NORM_BITS-1:0] o_n_reg;
    logic [OW-1:0]      o_d_reg;
    logic               o_deg_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            e_valid_reg  <= 1'b0;
            f_valid_reg  <= 1'b0;
            g_valid_reg  <= 1'b0;
            sq_valid_reg <= '0;
            dv_valid_reg <= '0;
            j_valid_reg  <= 1'b0;
            k_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg  <= in_valid;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            d_valid_reg  <= c_valid_reg;
            e_valid_reg  <= d_valid_reg;
            f_valid_reg  <= e_valid_reg;
            g_valid_reg  <= f_valid_reg;
            sq_valid_reg <= {sq_valid_reg[SQS-1:0], g_valid_reg};
            dv_valid_reg <= {dv_valid_reg[DVS-1:0], sq_valid_reg[SQS]};
            j_valid_reg  <= dv_valid_reg[DVS];
            k_valid_reg  <= j_valid_reg;
            o_valid_reg  <= k_valid_reg;
        end
    end

    // front end: differences, products, cross, length, scaling, squares
    logic [XW-1:0] e_or;
    logic [LW-1:0] e_len_next;
    always_comb
    begin
        e_or = '0;
        for (int i = 0; i < 3; i++)
        begin
            e_or = e_or | (d_x_reg[i][XW-1] ? (~d_x_reg[i] + 1'b1) : d_x_reg[i]);
        end
        e_len_next = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (e_or[i])
            begin
                e_len_next = LW'(i + 1);
            end
        end
    end

    logic [2:0][CCW-1:0] f_c_next;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (e_len_reg > LW'(CCW - 1))
            begin
                f_c_next[i] = CCW'($signed(e_x_reg[i]) >>> (e_len_reg - LW'(CCW - 1)));
            end
            else
            begin
                f_c_next[i] = e_x_reg[i][CCW-1:0] << (LW'(CCW - 1) - e_len_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_p_reg <= crd;
            for (int i = 0; i < 3; i++)
            begin
                b_v1_reg[i] <= DW'($signed(a_p_reg[3+i])) - DW'($signed(a_p_reg[i]));
                b_v2_reg[i] <= DW'($signed(a_p_reg[6+i])) - DW'($signed(a_p_reg[i]));
            end
            b_p1_reg <= a_p_reg[2:0];
            c_m_reg[0] <= PW'($signed(b_v1_reg[1]) * $signed(b_v2_reg[2]));
            c_m_reg[1] <= PW'($signed(b_v1_reg[2]) * $signed(b_v2_reg[1]));
            c_m_reg[2] <= PW'($signed(b_v1_reg[2]) * $signed(b_v2_reg[0]));
            c_m_reg[3] <= PW'($signed(b_v1_reg[0]) * $signed(b_v2_reg[2]));
            c_m_reg[4] <= PW'($signed(b_v1_reg[0]) * $signed(b_v2_reg[1]));
            c_m_reg[5] <= PW'($signed(b_v1_reg[1]) * $signed(b_v2_reg[0]));
            c_p1_reg <= b_p1_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_x_reg[i] <= XW'($signed(c_m_reg[2*i])) - XW'($signed(c_m_reg[2*i+1]));
            end
            d_p1_reg  <= c_p1_reg;
            e_x_reg   <= d_x_reg;
            e_len_reg <= e_len_next;
            e_p1_reg  <= d_p1_reg;
            f_c_reg   <= f_c_next;
            f_deg_reg <= (e_len_reg == '0);
            f_p1_reg  <= e_p1_reg;
            for (int i = 0; i < 3; i++)
            begin
                g_sq_reg[i] <= SW'($signed(f_c_reg[i]) * $signed(f_c_reg[i]));
                g_cr_reg.neg[i] <= f_c_reg[i][CCW-1];
                g_cr_reg.mag[i] <= f_c_reg[i][CCW-1] ? (~f_c_reg[i] + 1'b1) : f_c_reg[i];
            end
            g_cr_reg.p1  <= f_p1_reg;
            g_cr_reg.deg <= f_deg_reg;
            sq_x_reg[0]    <= g_sq_reg[0] + g_sq_reg[1] + g_sq_reg[2];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_cr_reg[0]   <= g_cr_reg;
        end
    end

    // square root, one result bit per stage
    genvar gs;
    generate
        for (gs = 0; gs < SQS; gs++)
        begin : g_sqrt
            logic [RMW-1:0] shifted;
            logic [RMW-1:0] trial;
            assign shifted = {sq_rem_reg[gs][RMW-3:0], sq_x_reg[gs][SW-1-2*gs -: 2]};
            assign trial   = {1'b0, sq_root_reg[gs], 2'b01};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_x_reg[gs+1]  <= sq_x_reg[gs];
                    sq_cr_reg[gs+1] <= sq_cr_reg[gs];
                    if (shifted >= trial)
                    begin
                        sq_rem_reg[gs+1]  <= shifted - trial;
                        sq_root_reg[gs+1] <= {sq_root_reg[gs][RTW-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg[gs+1]  <= shifted;
                        sq_root_reg[gs+1] <= {sq_root_reg[gs][RTW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // dividend setup
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_num_reg[0][i] <= {1'b0, sq_cr_reg[SQS].mag[i], {FS{1'b0}}}
                                    + NMW'(sq_root_reg[SQS] >> 1);
                dv_q_reg[0][i]   <= '0;
                dv_rem_reg[0][i] <= '0;
            end
            dv_m_reg[0]  <= sq_root_reg[SQS];
            dv_cr_reg[0] <= sq_cr_reg[SQS];
        end
    end

    // restoring divider, one quotient bit per stage; the top bits seed the remainder
    genvar gd;
    generate
        for (gd = 0; gd < DVS; gd++)
        begin : g_div
            logic [2:0][DRW-1:0] shifted;
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (gd == 0)
                    begin
                        shifted[i] = DRW'(dv_num_reg[gd][i] >> (QW - 1));
                    end
                    else
                    begin
                        shifted[i] = {dv_rem_reg[gd][i][DRW-2:0],
                                      dv_num_reg[gd][i][QW-1-gd]};
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_num_reg[gd+1] <= dv_num_reg[gd];
                    dv_m_reg[gd+1]   <= dv_m_reg[gd];
                    dv_cr_reg[gd+1]  <= dv_cr_reg[gd];
                    for (int i = 0; i < 3; i++)
                    begin
                        if (shifted[i] >= {1'b0, dv_m_reg[gd]})
                        begin
                            dv_rem_reg[gd+1][i] <= shifted[i] - {1'b0, dv_m_reg[gd]};
                            dv_q_reg[gd+1][i]   <= {dv_q_reg[gd][i][QW-2:0], 1'b1};
                        end
                        else
                        begin
                            dv_rem_reg[gd+1][i] <= shifted[i];
                            dv_q_reg[gd+1][i]   <= {dv_q_reg[gd][i][QW-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    // offset: products, sum, round, saturate
    logic signed [ACW-1:0]  acc;
    logic signed [SHW-1:0]  sh;
    logic signed [CMPW-1:0] shx;
    logic [OW-1:0]          d_sat;
    always_comb
    begin
        acc = -(ACW'($signed(k_pr_reg[0])) + ACW'($signed(k_pr_reg[1]))
                + ACW'($signed(k_pr_reg[2]))) + ACW'(1 << (FS - 1));
        sh  = SHW'(acc >>> FS);
        shx = CMPW'(sh);
        if (shx > CMPW'((64'sd1 <<< (OW - 1)) - 64'sd1))
        begin
            d_sat = {1'b0, {(OW-1){1'b1}}};
        end
        else if (shx < -CMPW'(64'sd1 <<< (OW - 1)))
        begin
            d_sat = {1'b1, {(OW-1){1'b0}}};
        end
        else
        begin
            d_sat = shx[OW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                j_n_reg[i] <= dv_cr_reg[DVS].neg[i] ? -NW'(dv_q_reg[DVS][i])
                                                     : NW'(dv_q_reg[DVS][i]);
                k_pr_reg[i] <= NPW'($signed(j_n_reg[i]) * $signed(j_p1_reg[i]));
            end
            j_p1_reg  <= dv_cr_reg[DVS].p1;
            j_deg_reg <= dv_cr_reg[DVS].deg;
            k_n_reg   <= j_n_reg;
            k_deg_reg <= j_deg_reg;
            for (int i = 0; i < 3; i++)
            begin
                o_n_reg[i] <= k_deg_reg ? '0 : k_n_reg[i][NORM_BITS-1:0];
            end
            o_d_reg   <= k_deg_reg ? '0 : d_sat;
            o_deg_reg <= k_deg_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign normal_x   = o_n_reg[0];
    assign normal_y   = o_n_reg[1];
    assign normal_z   = o_n_reg[2];
    assign offset_d   = o_d_reg;
    assign degenerate = o_deg_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for plane_from_three_points: directed table, then random point triples
// depends on plane3_pkg and plane_from_three_points

module tb_top;

    typedef struct {
        logic signed [31:0] pt [9];
        bit                 typed;
        logic signed [31:0] nx, ny, nz;
        logic signed [47:0] d;
        logic               degen;
    } plane_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [31:0] first_x = '0, first_y = '0, first_z = '0;
    logic [31:0] second_x = '0, second_y = '0, second_z = '0;
    logic [31:0] third_x = '0, third_y = '0, third_z = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [31:0] normal_x, normal_y, normal_z;
    logic signed [47:0] offset_d;
    logic degenerate;

    plane_word_t expected_planes[$];
    plane_word_t stim_table[$];
    int errors = 0;
    bit calm = 1'b0;

    plane_from_three_points DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("[plane_from_three_points] ERROR");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic plane_word_t solve_plane(plane_word_t w);
        logic signed [127:0] v1 [3], v2 [3], cr [3], c [3], acc, mag;
        logic [63:0] sum, m, q, cm;
        int len, l, j;
        plane_word_t r;
        r = w;
        len = 0;
        sum = 0;
        for (j = 0; j < 3; j++)
        begin
            v1[j] = 128'(w.pt[3 + j]) - 128'(w.pt[j]);
            v2[j] = 128'(w.pt[6 + j]) - 128'(w.pt[j]);
        end
        cr[0] = v1[1] * v2[2] - v1[2] * v2[1];
        cr[1] = v1[2] * v2[0] - v1[0] * v2[2];
        cr[2] = v1[0] * v2[1] - v1[1] * v2[0];
        for (j = 0; j < 3; j++)
        begin
            mag = cr[j] < 0 ? -cr[j] : cr[j];
            l = 0;
            while (mag != 0)
            begin
                l++;
                mag = mag >> 1;
            end
            if (l > len)
                len = l;
        end
        if (len == 0)
        begin
            r.nx = 0; r.ny = 0; r.nz = 0; r.d = 0; r.degen = 1'b1;
            return r;
        end
        for (j = 0; j < 3; j++)
        begin
            if (len > 31)
                c[j] = cr[j] >>> (len - 31);
            else
                c[j] = cr[j] <<< (31 - len);
            sum = sum + 64'(c[j] * c[j]);
        end
        m = int_sqrt(sum);
        if (m == 0)
            m = 1;
        acc = 0;
        for (j = 0; j < 3; j++)
        begin
            cm = c[j] < 0 ? 64'(-c[j]) : 64'(c[j]);
            q = ((cm << plane3_pkg::FRAC_SHIFT) + (m >> 1)) / m;
            c[j] = c[j] < 0 ? -128'(q) : 128'(q);
            acc = acc + c[j] * 128'(w.pt[j]);
        end
        r.nx = c[0][31:0];
        r.ny = c[1][31:0];
        r.nz = c[2][31:0];
        acc = (-acc + (128'sd1 <<< 29)) >>> plane3_pkg::FRAC_SHIFT;
        if (acc > 128'sd140737488355327)
            acc = 128'sd140737488355327;
        if (acc < -128'sd140737488355328)
            acc = -128'sd140737488355328;
        r.d = acc[47:0];
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic plane_word_t make_word(int a0, a1, a2, b0, b1, b2, c0, c1, c2);
        plane_word_t w;
        w.pt = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        w.typed = 1'b0;
        return w;
    endfunction

    function automatic plane_word_t with_result(plane_word_t w, int nx, ny, nz,
                                                longint d, bit dg);
        w.typed = 1'b1;
        w.nx = nx; w.ny = ny; w.nz = nz; w.d = d[47:0]; w.degen = dg;
        return w;
    endfunction

    function automatic int pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                           : 32'h8000_0000 + $urandom_range(0, 255);
            default: return $signed($urandom_range(0, 15)) - 8;
        endcase
    endfunction

    function automatic plane_word_t random_word();
        plane_word_t w;
        int mode, k, j;
        mode = $urandom_range(0, 3);
        for (j = 0; j < 9; j++)
            w.pt[j] = pick_coord(mode);
        case ($urandom_range(0, 9))
            0:
            begin
                // third point on the line through the first two
                k = $signed($urandom_range(0, 6)) - 3;
                for (j = 0; j < 3; j++)
                    w.pt[6 + j] = w.pt[j] + k * (w.pt[3 + j] - w.pt[j]);
            end
            1:
                for (j = 0; j < 3; j++)
                    w.pt[3 + j] = w.pt[j];
            default: ;
        endcase
        w.typed = 1'b0;
        return w;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_word(plane_word_t w);
        int g;
        g = draw_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        {first_x, first_y, first_z} <= {w.pt[0], w.pt[1], w.pt[2]};
        {second_x, second_y, second_z} <= {w.pt[3], w.pt[4], w.pt[5]};
        {third_x, third_y, third_z} <= {w.pt[6], w.pt[7], w.pt[8]};
        do
            @(posedge clk);
        while (in_stall);
        expected_planes.push_back(w.typed ? w : solve_plane(w));
    endtask

    initial
    begin
        int i, guard;
        stim_table.push_back(with_result(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1));
        stim_table.push_back(with_result(make_word(0, 0, 0, 'h10000, 0, 0, 0, 'h10000, 0),
                                         0, 0, 1 << 30, 0, 0));
        stim_table.push_back(with_result(make_word(0, 0, 'h10000, 'h10000, 0, 'h10000,
                                                   0, 'h10000, 'h10000),
                                         0, 0, 1 << 30, -65536, 0));
        stim_table.push_back(with_result(make_word('h7fffffff, 'h7fffffff, 'h7fffffff,
                                                   'h7fffffff, 'h7fffffff, 'h7fffffff,
                                                   'h7fffffff, 'h7fffffff, 'h7fffffff),
                                         0, 0, 0, 0, 1));
        stim_table.push_back(with_result(make_word('h80000000, 'h80000000, 'h80000000,
                                                   'h80000000, 'h80000000, 'h80000000,
                                                   0, 0, 0), 0, 0, 0, 0, 1));
        stim_table.push_back(with_result(make_word(1, 2, 3, 2, 4, 6, 3, 6, 9), 0, 0, 0, 0, 1));
        stim_table.push_back(make_word('h80000000, 'h80000000, 'h80000000,
                                       'h7fffffff, 'h80000000, 'h80000000,
                                       'h80000000, 'h7fffffff, 'h80000000));
        stim_table.push_back(make_word('h7fffffff, 'h7fffffff, 'h7fffffff,
                                       'h80000000, 'h7fffffff, 'h7fffffff,
                                       'h7fffffff, 'h80000000, 'h80000000));
        stim_table.push_back(make_word('h80000000, 0, 'h7fffffff, 'h7fffffff, 'h80000000, 0,
                                       0, 'h7fffffff, 'h80000000));
        stim_table.push_back(make_word(0, 0, 0, 1, 0, 0, 0, 1, 0));
        stim_table.push_back(make_word(0, 0, 0, 1, 0, 0, 0, 0, -1));
        stim_table.push_back(make_word(5, -7, 3, 5, -7, 4, 6, -7, 3));
        stim_table.push_back(make_word('h7fffffff, 0, 0, 0, 'h7fffffff, 0, 0, 0, 'h7fffffff));
        stim_table.push_back(make_word('hffffffff, 'hffffffff, 'hffffffff, 1, 1, 1, 1, -1, 1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_table[r])
            send_word(stim_table[r]);
        for (i = 0; i < 1800; i++)
        begin
            if (i % 200 == 0)
                calm <= ($urandom_range(0, 2) == 0);
            if (i == 900)
            begin
                // drain the pipeline before carrying on
                in_valid <= 1'b0;
                while (expected_planes.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            send_word(random_word());
        end
        in_valid <= 1'b0;
        guard = 0;
        while (expected_planes.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_planes.size() == 0)
            $display("[plane_from_three_points] OK");
        else
            $display("[plane_from_three_points] ERROR");
        $finish;
    end

    initial
    begin
        int s;
        plane_word_t e;
        @(posedge rst_n);
        forever
        begin
            s = draw_gap();
            if (s > 0)
            begin
                out_stall <= 1'b1;
                repeat (s) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (expected_planes.size() == 0)
            begin
                $error("word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_planes.pop_front();
                if (normal_x !== e.nx)
                begin
                    $error("normal_x expected %0d got %0d", e.nx, normal_x);
                    errors++;
                end
                if (normal_y !== e.ny)
                begin
                    $error("normal_y expected %0d got %0d", e.ny, normal_y);
                    errors++;
                end
                if (normal_z !== e.nz)
                begin
                    $error("normal_z expected %0d got %0d", e.nz, normal_z);
                    errors++;
                end
                if (offset_d !== e.d)
                begin
                    $error("offset_d expected %0d got %0d", e.d, offset_d);
                    errors++;
                end
                if (degenerate !== e.degen)
                begin
                    $error("degenerate expected %0d got %0d", e.degen, degenerate);
                    errors++;
                end
            end
        end
    end

endmodule

/* filelist.f */
sv/plane3_pkg.sv
sv/plane_from_three_points.sv
tb/tb_top.sv
